// ----- hdl/lss_pkg.sv -----
// shared types and constants for the link and sync supervisor
package lss_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned STREAK_W = 8;
  localparam int unsigned BACKOFF_W = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RECONNECT_INTERVAL = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_CONNECT_TIMEOUT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DROP_TIMEOUT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SYNC_TIMEOUT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RESYNC_INTERVAL = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SYNC_FAIL_LIMIT = 3'd5;

  // register reset values
  localparam logic [TIME_W-1:0] RST_RECONNECT_INTERVAL = 32'd5000;
  localparam logic [TIME_W-1:0] RST_INIT_CONNECT_TIMEOUT = 32'd60000;
  localparam logic [TIME_W-1:0] RST_DROP_TIMEOUT = 32'd300000;
  localparam logic [TIME_W-1:0] RST_SYNC_TIMEOUT = 32'd8000;
  localparam logic [TIME_W-1:0] RST_RESYNC_INTERVAL = 32'd3600000;
  localparam logic [STREAK_W-1:0] RST_SYNC_FAIL_LIMIT = 8'd5;

  // backoff steps and streak saturation
  localparam logic [BACKOFF_W-1:0] BACKOFF_SHORT = 16'd10000;
  localparam logic [BACKOFF_W-1:0] BACKOFF_MID = 16'd30000;
  localparam logic [BACKOFF_W-1:0] BACKOFF_LONG = 16'd60000;
  localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

  typedef enum logic [1:0] {
    MODE_CONNECTING = 2'd0,
    MODE_SYNCING    = 2'd1,
    MODE_READY      = 2'd2,
    MODE_FAILED     = 2'd3
  } mode_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              link_up;
    logic              sync_ok;
    logic [CHAN_W-1:0] channel;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           link_state;
    logic                 reconnect_req;
    logic [CHAN_W-1:0]    reconnect_channel;
    logic                 restart_req;
    logic                 sync_started;
    logic                 first_connect;
    logic                 fetch_config;
    logic                 uplink_ready;
    logic [BACKOFF_W-1:0] retry_backoff_ms;
  } out_word_t;

  typedef struct packed {
    logic [TIME_W-1:0]   reconnect_interval_ms;
    logic [TIME_W-1:0]   init_connect_timeout_ms;
    logic [TIME_W-1:0]   drop_timeout_ms;
    logic [TIME_W-1:0]   sync_timeout_ms;
    logic [TIME_W-1:0]   resync_interval_ms;
    logic [STREAK_W-1:0] sync_fail_limit;
  } cfg_t;

  // backoff picked by the failure streak
  function automatic logic [BACKOFF_W-1:0] backoff_for(input logic [STREAK_W-1:0] streak);
    logic [BACKOFF_W-1:0] b;
    if (streak <= 8'd1) begin
      b = BACKOFF_SHORT;
    end else if (streak == 8'd2) begin
      b = BACKOFF_MID;
    end else begin
      b = BACKOFF_LONG;
    end
    return b;
  endfunction

endpackage

// ----- hdl/link_sync_supervisor_core.sv -----
// top level of the link and clock sync supervisor
//
// One input word is one poll tick: time, link status, sync result and channel.
// Every tick yields exactly one result word: state, reconnect and restart
// requests, sync start, first-connect and config-fetch flags and the backoff.
// Both channels use valid/stall; a word moves at an edge with valid high and
// stall low. The block takes one word per cycle, back to back, while the receiver does not stall.
// A word lands in the input register, then the decision logic updates the
// supervisor state and loads the result register. The state loop is one pass
// of compares and adds, so a tick can follow every cycle.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; in_stall rises only when both are full.
// Configuration is a plain write port (cfg_we, cfg_addr, cfg_data); the user must
// write it only while the block is idle, which the block does not enforce; unused indexes are ignored.
// Synchronous reset restores the register defaults, the connecting state and
// empties both registers.
module link_sync_supervisor_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lss_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lss_pkg::out_word_t              out_data,
  input  logic                            cfg_we,
  input  logic [lss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lss_pkg::*;

  cfg_t       cfg;
  logic       in_full;
  in_word_t   in_q;
  out_word_t  step_word;
  logic       out_free;
  logic       advance;

  assign out_free = !out_valid || !out_stall;
  assign advance = in_full && out_free;
  assign in_stall = in_full && !out_free;

  lss_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  lss_step u_step (
    .clk      (clk),
    .rst      (rst),
    .commit   (advance),
    .in_word  (in_q),
    .cfg      (cfg),
    .out_word (step_word)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_word;
    end
  end

  // checks on the block's own logic
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled while a register was free");

  a_ready_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.uplink_ready == (out_data.link_state == MODE_READY)))
    else $error("uplink_ready disagrees with link_state");

  a_backoff_only_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.retry_backoff_ms != '0) |-> (out_data.link_state == MODE_FAILED))
    else $error("backoff reported outside the failed state");

  a_start_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.sync_started) |->
      (out_data.link_state == MODE_SYNCING || out_data.link_state == MODE_READY))
    else $error("sync started but state is neither syncing nor ready");

  a_channel_without_req: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.reconnect_req) |-> (out_data.reconnect_channel == '0))
    else $error("reconnect channel set without a request");

endmodule

// ----- hdl/lss_cfg_regs.sv -----
// configuration registers of the supervisor
module lss_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lss_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lss_pkg::cfg_t                   cfg
);
  import lss_pkg::*;

  // register file with write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reconnect_interval_ms <= RST_RECONNECT_INTERVAL;
      cfg.init_connect_timeout_ms <= RST_INIT_CONNECT_TIMEOUT;
      cfg.drop_timeout_ms <= RST_DROP_TIMEOUT;
      cfg.sync_timeout_ms <= RST_SYNC_TIMEOUT;
      cfg.resync_interval_ms <= RST_RESYNC_INTERVAL;
      cfg.sync_fail_limit <= RST_SYNC_FAIL_LIMIT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RECONNECT_INTERVAL: cfg.reconnect_interval_ms <= cfg_data;
        REG_INIT_CONNECT_TIMEOUT: cfg.init_connect_timeout_ms <= cfg_data;
        REG_DROP_TIMEOUT: cfg.drop_timeout_ms <= cfg_data;
        REG_SYNC_TIMEOUT: cfg.sync_timeout_ms <= cfg_data;
        REG_RESYNC_INTERVAL: cfg.resync_interval_ms <= cfg_data;
        REG_SYNC_FAIL_LIMIT: cfg.sync_fail_limit <= cfg_data[STREAK_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/lss_step.sv -----
// per-tick decision logic and supervisor state
module lss_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                commit,
  input  lss_pkg::in_word_t   in_word,
  input  lss_pkg::cfg_t       cfg,
  output lss_pkg::out_word_t  out_word
);
  import lss_pkg::*;

  mode_t                 mode_state, mode_next;
  logic                  down_valid, down_valid_next;
  logic [TIME_W-1:0]     down_since_ms, down_since_ms_next;
  logic [TIME_W-1:0]     last_reconnect_ms, last_reconnect_ms_next;
  logic [CHAN_W-1:0]     last_channel, last_channel_next;
  logic                  ever_connected, ever_connected_next;
  logic [TIME_W-1:0]     sync_start_ms, sync_start_ms_next;
  logic [TIME_W-1:0]     last_resync_ms, last_resync_ms_next;
  logic [TIME_W-1:0]     next_sync_ms, next_sync_ms_next;
  logic [STREAK_W-1:0]   fail_streak, fail_streak_next;
  logic                  config_fetched, config_fetched_next;

  logic [TIME_W-1:0]     now;
  logic [TIME_W-1:0]     down_ref;
  logic [TIME_W-1:0]     limit;
  logic [TIME_W-1:0]     since_reconnect, since_down, since_resync, since_sync, since_retry;
  logic                  start;
  mode_t                 mode_mid;
  logic [STREAK_W-1:0]   streak_inc;
  logic [BACKOFF_W-1:0]  backoff;

  assign now = in_word.now_ms;
  assign down_ref = down_valid ? down_since_ms : now;
  assign limit = ever_connected ? cfg.drop_timeout_ms : cfg.init_connect_timeout_ms;

  // wrapping elapsed times
  assign since_reconnect = now - last_reconnect_ms;
  assign since_down = now - down_ref;
  assign since_resync = now - last_resync_ms;
  assign since_sync = now - sync_start_ms;
  assign since_retry = now - next_sync_ms;

  assign streak_inc = (fail_streak < STREAK_MAX) ? fail_streak + 8'd1 : fail_streak;
  assign backoff = backoff_for(streak_inc);

  // next state and result word for one tick
  always_comb begin
    mode_next = mode_state;
    down_valid_next = down_valid;
    down_since_ms_next = down_since_ms;
    last_reconnect_ms_next = last_reconnect_ms;
    last_channel_next = last_channel;
    ever_connected_next = ever_connected;
    sync_start_ms_next = sync_start_ms;
    last_resync_ms_next = last_resync_ms;
    next_sync_ms_next = next_sync_ms;
    fail_streak_next = fail_streak;
    config_fetched_next = config_fetched;
    out_word = '0;
    start = 1'b0;
    mode_mid = mode_state;

    if (!in_word.link_up) begin
      // link down: throttled reconnect and restart watchdog
      mode_next = MODE_CONNECTING;
      if (!down_valid) begin
        down_valid_next = 1'b1;
        down_since_ms_next = now;
      end
      if (since_reconnect > cfg.reconnect_interval_ms) begin
        last_reconnect_ms_next = now;
        out_word.reconnect_req = 1'b1;
        out_word.reconnect_channel = last_channel;
      end
      if (since_down > limit) begin
        out_word.restart_req = 1'b1;
      end
    end else begin
      // link up: decide whether a sync starts
      if (down_valid) begin
        down_valid_next = 1'b0;
        down_since_ms_next = '0;
        last_channel_next = in_word.channel;
        if (!ever_connected) begin
          ever_connected_next = 1'b1;
          out_word.first_connect = 1'b1;
        end
        start = 1'b1;
      end else if (mode_state == MODE_FAILED) begin
        start = !since_retry[TIME_W-1];
      end else if (mode_state != MODE_SYNCING && since_resync > cfg.resync_interval_ms) begin
        start = 1'b1;
      end
      if (start) begin
        sync_start_ms_next = now;
        last_resync_ms_next = now;
        mode_mid = MODE_SYNCING;
        out_word.sync_started = 1'b1;
      end
      mode_next = mode_mid;
      // sync in progress: success or timeout
      if (mode_mid == MODE_SYNCING) begin
        if (in_word.sync_ok) begin
          mode_next = MODE_READY;
          fail_streak_next = '0;
          if (!config_fetched) begin
            config_fetched_next = 1'b1;
            out_word.fetch_config = 1'b1;
          end
        end else if ((start ? '0 : since_sync) > cfg.sync_timeout_ms) begin
          fail_streak_next = streak_inc;
          if (streak_inc > cfg.sync_fail_limit) begin
            out_word.restart_req = 1'b1;
          end
          out_word.retry_backoff_ms = backoff;
          next_sync_ms_next = now + {{(TIME_W-BACKOFF_W){1'b0}}, backoff};
          mode_next = MODE_FAILED;
          if (!config_fetched) begin
            config_fetched_next = 1'b1;
            out_word.fetch_config = 1'b1;
          end
        end
      end
    end

    out_word.link_state = mode_next;
    out_word.uplink_ready = (mode_next == MODE_READY);
  end

  // state registers, updated when a word moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state <= MODE_CONNECTING;
      down_valid <= 1'b0;
      down_since_ms <= '0;
      last_reconnect_ms <= '0;
      last_channel <= '0;
      ever_connected <= 1'b0;
      sync_start_ms <= '0;
      last_resync_ms <= '0;
      next_sync_ms <= '0;
      fail_streak <= '0;
      config_fetched <= 1'b0;
    end else if (commit) begin
      mode_state <= mode_next;
      down_valid <= down_valid_next;
      down_since_ms <= down_since_ms_next;
      last_reconnect_ms <= last_reconnect_ms_next;
      last_channel <= last_channel_next;
      ever_connected <= ever_connected_next;
      sync_start_ms <= sync_start_ms_next;
      last_resync_ms <= last_resync_ms_next;
      next_sync_ms <= next_sync_ms_next;
      fail_streak <= fail_streak_next;
      config_fetched <= config_fetched_next;
    end
  end

endmodule

// ----- verif/tb_link_sync_supervisor_core.sv -----
// testbench for the link and clock sync supervisor core
`timescale 1ns / 1ps

module tb_link_sync_supervisor_core;
  import lss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_SHOWN = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // idle knobs for the sending and receiving sides
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  // supervisor copy: registers and state
  cfg_t sup_cfg;
  mode_t sup_mode;
  logic sup_down_valid;
  logic [TIME_W-1:0] sup_down_since;
  logic [TIME_W-1:0] sup_last_reconnect;
  logic [CHAN_W-1:0] sup_last_channel;
  logic sup_ever_connected;
  logic [TIME_W-1:0] sup_sync_start;
  logic [TIME_W-1:0] sup_last_resync;
  logic [TIME_W-1:0] sup_next_sync;
  logic [STREAK_W-1:0] sup_streak;
  logic sup_config_fetched;

  out_word_t pending_reports[$];
  out_word_t want;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic [TIME_W-1:0] tick_ms = '0;

  link_sync_supervisor_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.reconnect_interval_ms = RST_RECONNECT_INTERVAL;
    c.init_connect_timeout_ms = RST_INIT_CONNECT_TIMEOUT;
    c.drop_timeout_ms = RST_DROP_TIMEOUT;
    c.sync_timeout_ms = RST_SYNC_TIMEOUT;
    c.resync_interval_ms = RST_RESYNC_INTERVAL;
    c.sync_fail_limit = RST_SYNC_FAIL_LIMIT;
    return c;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_word_t poll_word(input logic [TIME_W-1:0] now, input logic up,
                                         input logic ok, input logic [CHAN_W-1:0] ch);
    in_word_t w;
    w.now_ms = now;
    w.link_up = up;
    w.sync_ok = ok;
    w.channel = ch;
    return w;
  endfunction

  // one poll tick of the supervisor: updates the copy, returns the report
  function automatic out_word_t supervise_tick(input in_word_t w);
    out_word_t r;
    logic [TIME_W-1:0] down_limit;
    logic [TIME_W-1:0] retry_gap;
    logic begin_sync;
    r = '0;
    begin_sync = 1'b0;
    if (!w.link_up) begin
      // link down: throttled reconnect and restart on long outage
      sup_mode = MODE_CONNECTING;
      if (!sup_down_valid) begin
        sup_down_valid = 1'b1;
        sup_down_since = w.now_ms;
      end
      if (w.now_ms - sup_last_reconnect > sup_cfg.reconnect_interval_ms) begin
        sup_last_reconnect = w.now_ms;
        r.reconnect_req = 1'b1;
        r.reconnect_channel = sup_last_channel;
      end
      down_limit = sup_ever_connected ? sup_cfg.drop_timeout_ms
                                      : sup_cfg.init_connect_timeout_ms;
      if (w.now_ms - sup_down_since > down_limit) r.restart_req = 1'b1;
    end else begin
      // link up: connect event, backoff retry or routine re-sync
      retry_gap = w.now_ms - sup_next_sync;
      if (sup_down_valid) begin
        sup_down_valid = 1'b0;
        sup_down_since = '0;
        sup_last_channel = w.channel;
        if (!sup_ever_connected) begin
          sup_ever_connected = 1'b1;
          r.first_connect = 1'b1;
        end
        begin_sync = 1'b1;
      end else if (sup_mode == MODE_FAILED) begin
        if (!retry_gap[TIME_W-1]) begin_sync = 1'b1;
      end else if (sup_mode != MODE_SYNCING &&
                   w.now_ms - sup_last_resync > sup_cfg.resync_interval_ms) begin
        begin_sync = 1'b1;
      end
      if (begin_sync) begin
        sup_sync_start = w.now_ms;
        sup_last_resync = w.now_ms;
        sup_mode = MODE_SYNCING;
        r.sync_started = 1'b1;
      end
      // sync outcome
      if (sup_mode == MODE_SYNCING) begin
        if (w.sync_ok) begin
          sup_mode = MODE_READY;
          sup_streak = '0;
          if (!sup_config_fetched) begin
            sup_config_fetched = 1'b1;
            r.fetch_config = 1'b1;
          end
        end else if (w.now_ms - sup_sync_start > sup_cfg.sync_timeout_ms) begin
          if (sup_streak != STREAK_MAX) sup_streak = sup_streak + 1'b1;
          if (sup_streak > sup_cfg.sync_fail_limit) r.restart_req = 1'b1;
          if (sup_streak <= 1) r.retry_backoff_ms = BACKOFF_SHORT;
          else if (sup_streak == 2) r.retry_backoff_ms = BACKOFF_MID;
          else r.retry_backoff_ms = BACKOFF_LONG;
          sup_next_sync = w.now_ms + r.retry_backoff_ms;
          sup_mode = MODE_FAILED;
          if (!sup_config_fetched) begin
            sup_config_fetched = 1'b1;
            r.fetch_config = 1'b1;
          end
        end
      end
    end
    r.link_state = sup_mode;
    r.uplink_ready = (sup_mode == MODE_READY);
    return r;
  endfunction

  // predict on each accepted input word, check each accepted result word
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) pending_reports.push_back(supervise_tick(in_data));
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MAX_SHOWN)
            $display("unexpected result word %h at cycle %0d", out_data, cycle_count);
        end else begin
          want = pending_reports.pop_front();
          if (out_data.link_state !== want.link_state ||
              out_data.reconnect_req !== want.reconnect_req ||
              out_data.reconnect_channel !== want.reconnect_channel ||
              out_data.restart_req !== want.restart_req ||
              out_data.sync_started !== want.sync_started ||
              out_data.first_connect !== want.first_connect ||
              out_data.fetch_config !== want.fetch_config ||
              out_data.uplink_ready !== want.uplink_ready ||
              out_data.retry_backoff_ms !== want.retry_backoff_ms) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < MAX_SHOWN)
              $display({"mismatch at cycle %0d: state %0d/%0d rc %0b/%0b ch %0d/%0d ",
                        "restart %0b/%0b start %0b/%0b first %0b/%0b fetch %0b/%0b ",
                        "ready %0b/%0b backoff %0d/%0d (expected/actual)"},
                       cycle_count, want.link_state, out_data.link_state,
                       want.reconnect_req, out_data.reconnect_req,
                       want.reconnect_channel, out_data.reconnect_channel,
                       want.restart_req, out_data.restart_req,
                       want.sync_started, out_data.sync_started,
                       want.first_connect, out_data.first_connect,
                       want.fetch_config, out_data.fetch_config,
                       want.uplink_ready, out_data.uplink_ready,
                       want.retry_backoff_ms, out_data.retry_backoff_ms);
          end
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int run;
    @(posedge clk);
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      run = out_idle_on ? pick_gap() : 0;
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  // send one input word, then an optional gap
  task automatic send_word(input in_word_t w);
    int gap;
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // step past the coming edge first so a word accepted there is already queued
  task automatic wait_reports_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // write every register while the block is idle
  task automatic apply_cfg(input cfg_t c);
    logic [CFG_DATA_W-1:0] limit_word;
    wait_reports_done();
    limit_word = $urandom;
    limit_word[STREAK_W-1:0] = c.sync_fail_limit;
    write_reg(REG_RECONNECT_INTERVAL, c.reconnect_interval_ms);
    write_reg(REG_INIT_CONNECT_TIMEOUT, c.init_connect_timeout_ms);
    write_reg(REG_DROP_TIMEOUT, c.drop_timeout_ms);
    write_reg(REG_SYNC_TIMEOUT, c.sync_timeout_ms);
    write_reg(REG_RESYNC_INTERVAL, c.resync_interval_ms);
    write_reg(REG_SYNC_FAIL_LIMIT, limit_word);
    cfg_we <= 1'b0;
    sup_cfg = c;
  endtask

  function automatic logic [TIME_W-1:0] random_time_reg(input logic [TIME_W-1:0] dflt);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return dflt;
    if (r < 9) return $urandom_range(0, 2 * dflt);
    return $urandom;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    int r;
    c.reconnect_interval_ms = random_time_reg(RST_RECONNECT_INTERVAL);
    c.init_connect_timeout_ms = random_time_reg(RST_INIT_CONNECT_TIMEOUT);
    c.drop_timeout_ms = random_time_reg(RST_DROP_TIMEOUT);
    c.sync_timeout_ms = random_time_reg(RST_SYNC_TIMEOUT);
    c.resync_interval_ms = random_time_reg(RST_RESYNC_INTERVAL);
    r = $urandom_range(0, 3);
    if (r == 0) c.sync_fail_limit = '0;
    else if (r == 1) c.sync_fail_limit = STREAK_MAX;
    else if (r == 2) c.sync_fail_limit = STREAK_W'($urandom_range(1, 8));
    else c.sync_fail_limit = STREAK_W'($urandom);
    return c;
  endfunction

  // time advance: mostly short, some past the timeouts, rarely a wild jump
  function automatic logic [TIME_W-1:0] time_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 3000);
    if (r < 85) return $urandom_range(0, 20000);
    if (r < 97) return $urandom_range(0, 400000);
    return $urandom;
  endfunction

  // down and up stretches with random content, plus some noise words
  task automatic drive_link_sessions(input int n_items);
    int sent;
    int kind;
    int len;
    int ok_pct;
    logic [CHAN_W-1:0] ch;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          tick_ms = tick_ms + time_step();
          send_word(poll_word(tick_ms, 1'b0, 1'($urandom_range(0, 1)), CHAN_W'($urandom)));
        end
      end else if (kind < 9) begin
        len = $urandom_range(1, 20);
        ch = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                         : CHAN_W'($urandom);
        case ($urandom_range(0, 2))
          0: ok_pct = 0;
          1: ok_pct = 10;
          default: ok_pct = 40;
        endcase
        repeat (len) begin
          tick_ms = tick_ms + time_step();
          send_word(poll_word(tick_ms, 1'b1, $urandom_range(0, 99) < ok_pct, ch));
        end
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_word(in_word_t'({$urandom, 10'($urandom)}));
      end
      sent = sent + len;
    end
  endtask

  // reset values, connect and drop timeouts, backoff steps, time wrap
  task automatic test_reset_defaults();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    // link up on the very first tick: no connection event
    send_word(poll_word(32'd0, 1'b1, 1'b1, 8'd0));
    // periodic re-sync while still connecting
    send_word(poll_word(32'd3600001, 1'b1, 1'b0, 8'd0));
    send_word(poll_word(32'd3600002, 1'b1, 1'b1, 8'd0));
    // throttled reconnect, full scan, then never-connected restart
    send_word(poll_word(32'd3600100, 1'b0, 1'b0, 8'd77));
    send_word(poll_word(32'd3602000, 1'b0, 1'b0, 8'd0));
    send_word(poll_word(32'd3605101, 1'b0, 1'b0, 8'd0));
    send_word(poll_word(32'd3660101, 1'b0, 1'b0, 8'd0));
    // first connect, sync timeout, retry held until backoff ends
    send_word(poll_word(32'd3660200, 1'b1, 1'b0, 8'd255));
    send_word(poll_word(32'd3668201, 1'b1, 1'b0, 8'd255));
    send_word(poll_word(32'd3670000, 1'b1, 1'b1, 8'd255));
    send_word(poll_word(32'd3678201, 1'b1, 1'b1, 8'd255));
    // drop: reconnect pinned to the last channel, drop timeout restart
    send_word(poll_word(32'd3678300, 1'b0, 1'b1, 8'd3));
    send_word(poll_word(32'd3978301, 1'b0, 1'b0, 8'd3));
    // reconnect and a failure chain through the three backoff steps
    send_word(poll_word(32'd3978400, 1'b1, 1'b0, 8'd0));
    send_word(poll_word(32'd3986401, 1'b1, 1'b0, 8'd0));
    send_word(poll_word(32'd3996401, 1'b1, 1'b0, 8'd0));
    send_word(poll_word(32'd4004402, 1'b1, 1'b0, 8'd0));
    send_word(poll_word(32'd4034402, 1'b1, 1'b0, 8'd0));
    send_word(poll_word(32'd4042403, 1'b1, 1'b0, 8'd0));
    // time wrap across a drop and reconnect, then a huge re-sync gap
    send_word(poll_word(32'hFFFF_FFFF, 1'b0, 1'b1, 8'd200));
    send_word(poll_word(32'd10, 1'b1, 1'b1, 8'd200));
    send_word(poll_word(32'h7FFF_FFFF, 1'b1, 1'b0, 8'd200));
    tick_ms = 32'h7FFF_FFFF;
  endtask

  // all registers at zero, then all at their maximum
  task automatic test_register_extremes();
    apply_cfg('0);
    drive_link_sessions(120);
    apply_cfg('1);
    drive_link_sessions(120);
  endtask

  // long failure chain drives the streak into saturation past the limit
  task automatic test_failure_streak_saturation();
    cfg_t c;
    c = default_cfg();
    c.sync_timeout_ms = '0;
    c.sync_fail_limit = STREAK_MAX - 8'd1;
    apply_cfg(c);
    tick_ms = tick_ms + 32'd1000;
    send_word(poll_word(tick_ms, 1'b0, 1'b0, CHAN_W'($urandom)));
    tick_ms = tick_ms + 32'd1;
    send_word(poll_word(tick_ms, 1'b1, 1'b0, CHAN_W'($urandom)));
    repeat (260) begin
      tick_ms = tick_ms + 32'd1;
      send_word(poll_word(tick_ms, 1'b1, 1'b0, CHAN_W'($urandom)));
      tick_ms = tick_ms + BACKOFF_LONG + $urandom_range(0, 500);
      send_word(poll_word(tick_ms, 1'b1, 1'b0, CHAN_W'($urandom)));
    end
  endtask

  // reset values written back, then random register sets
  task automatic test_random_configs();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    apply_cfg(default_cfg());
    drive_link_sessions(50);
    for (int p = 0; p < 4; p++) begin
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      apply_cfg(random_cfg());
      drive_link_sessions(50);
    end
  endtask

  initial begin
    sup_cfg = default_cfg();
    sup_mode = MODE_CONNECTING;
    sup_down_valid = 1'b0;
    sup_down_since = '0;
    sup_last_reconnect = '0;
    sup_last_channel = '0;
    sup_ever_connected = 1'b0;
    sup_sync_start = '0;
    sup_last_resync = '0;
    sup_next_sync = '0;
    sup_streak = '0;
    sup_config_fetched = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_failure_streak_saturation();
    test_random_configs();
    wait_reports_done();
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lss_pkg.sv
hdl/lss_cfg_regs.sv
hdl/lss_step.sv
hdl/link_sync_supervisor_core.sv
verif/tb_link_sync_supervisor_core.sv
